// File: design/pmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared widths, command and status codes, and the probe record that walks
// the cell chain of the page mapping table.
// ----------------------------------------------------------------------------
package pmt_pkg;

  localparam int unsigned VPAGE_W  = 52;
  localparam int unsigned PPAGE_W  = 20;
  localparam int unsigned STATUS_W = 2;

  // Command codes
  localparam logic CMD_MAP       = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // Probe handed from cell to cell. ppage/writable carry the new values on
  // the way in and the found values once a translate has hit.
  typedef struct packed {
    logic               valid;
    logic               command;
    logic [VPAGE_W-1:0] vpage;
    logic [PPAGE_W-1:0] ppage;
    logic               writable;
    logic               done;      // matched or appended somewhere upstream
    logic               appended;  // a new entry was added
  } probe_t;

endpackage

// File: design/page_mapping_table.sv
`timescale 1ns / 1ps
// The probe walks one cell of the chain per cycle, from the head register
// through the slot cells in order to the output register.
// A new item is taken only after the previous result transfer.
// Reset: synchronous, active low; empties the table at once (fill count to
// zero), no clearing pass.
// ----------------------------------------------------------------------------
// page_mapping_table
// Fully associative virtual-to-physical page table built as a chain of slot
// cells. Entries fill slots in order; the fill count lives here.
// ----------------------------------------------------------------------------
module page_mapping_table #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic [pmt_pkg::VPAGE_W-1:0]       in_virtual_page,
  input  logic [pmt_pkg::PPAGE_W-1:0]       in_new_physical_page,
  input  logic                              in_new_writable,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pmt_pkg::STATUS_W-1:0]      out_status,
  output logic [pmt_pkg::PPAGE_W-1:0]       out_found_physical_page,
  output logic                              out_found_writable
);
  import pmt_pkg::*;

  localparam int unsigned USED_W = $clog2(MAX_ENTRIES + 1);

  logic                  busy_r;
  logic [USED_W-1:0]     used_r;
  probe_t                head_r;
  probe_t                chain [MAX_ENTRIES+1];
  probe_t                tail;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   status_r;
  logic [PPAGE_W-1:0]    found_ppage_r;
  logic                  found_wr_r;
  logic                  in_xfer;
  logic                  out_xfer;
  logic [STATUS_W-1:0]   status_nxt;
  logic                  found;

  assign in_stall = busy_r;
  assign in_xfer  = in_valid && !busy_r;
  assign out_xfer = out_valid_r && !out_stall;

  // One item in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_xfer) begin
      busy_r <= 1'b1;
    end else if (out_xfer) begin
      busy_r <= 1'b0;
    end
  end

  // Chain head register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
    end else begin
      head_r.valid <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      head_r.command  <= in_command;
      head_r.vpage    <= in_virtual_page;
      head_r.ppage    <= in_new_physical_page;
      head_r.writable <= in_new_writable;
      head_r.done     <= 1'b0;
      head_r.appended <= 1'b0;
    end
  end

  assign chain[0] = head_r;

  // Row of slot cells
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    pmt_cell #(
      .IDX    (k),
      .USED_W (USED_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .used    (used_r),
      .probe_i (chain[k]),
      .probe_o (chain[k+1])
    );
  end

  assign tail = chain[MAX_ENTRIES];

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (tail.valid && tail.appended) begin
      used_r <= used_r + USED_W'(1);
    end
  end

  // Result decode
  assign found = tail.done && (tail.command == CMD_TRANSLATE);

  always_comb begin
    if (tail.done) begin
      status_nxt = ST_OK;
    end else if (tail.command == CMD_MAP) begin
      status_nxt = ST_FULL;
    end else begin
      status_nxt = ST_NOT_FOUND;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tail.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      status_r      <= status_nxt;
      found_ppage_r <= found ? tail.ppage : '0;
      found_wr_r    <= found ? tail.writable : 1'b0;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status              = status_r;
  assign out_found_physical_page = found_ppage_r;
  assign out_found_writable      = found_wr_r;

endmodule

// File: design/pmt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_cell
// One table slot. Compares the passing probe against its entry, updates or
// fills the entry on a map, picks up the mapping on a translate, and hands
// the probe on through a register.
// ----------------------------------------------------------------------------
module pmt_cell #(
  parameter int unsigned IDX    = 0,
  parameter int unsigned USED_W = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [USED_W-1:0]   used,
  input  pmt_pkg::probe_t     probe_i,
  output pmt_pkg::probe_t     probe_o
);
  import pmt_pkg::*;

  logic [VPAGE_W-1:0] ent_vpage_r;
  logic [PPAGE_W-1:0] ent_ppage_r;
  logic               ent_wr_r;

  logic               live;
  logic               in_range;
  logic               match;
  logic               append;
  logic               wr_en;
  probe_t             probe_nxt;
  probe_t             probe_r;

  // Slot state relative to the fill count
  assign live     = probe_i.valid && !probe_i.done;
  assign in_range = USED_W'(IDX) < used;
  assign match    = live && in_range && (ent_vpage_r == probe_i.vpage);
  assign append   = live && (probe_i.command == CMD_MAP) && (USED_W'(IDX) == used);
  assign wr_en    = append || (match && (probe_i.command == CMD_MAP));

  // Next probe
  always_comb begin
    probe_nxt          = probe_i;
    probe_nxt.done     = probe_i.done || match || append;
    probe_nxt.appended = probe_i.appended || append;
    if (match && (probe_i.command == CMD_TRANSLATE)) begin
      probe_nxt.ppage    = ent_ppage_r;
      probe_nxt.writable = ent_wr_r;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_ppage_r <= probe_i.ppage;
      ent_wr_r    <= probe_i.writable;
    end
    if (append) begin
      ent_vpage_r <= probe_i.vpage;
    end
  end

  // Hand-on register: valid is control, the rest is payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r.valid <= probe_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    probe_r.command  <= probe_nxt.command;
    probe_r.vpage    <= probe_nxt.vpage;
    probe_r.ppage    <= probe_nxt.ppage;
    probe_r.writable <= probe_nxt.writable;
    probe_r.done     <= probe_nxt.done;
    probe_r.appended <= probe_nxt.appended;
  end

  assign probe_o = probe_r;

endmodule

// File: tb/tb_page_mapping_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_mapping_table
// Self-checking bench for the page mapping table. A directed sequence covers
// lookups on an empty table, new mappings, updates, misses and a full table.
// It is followed by random map and translate traffic drawn mostly from known
// pages. A tracker class keeps its own copy of the table. It predicts each
// result and compares it with what the block returns. Both channels idle at
// random, apart from one quiet stretch on each side.
// ----------------------------------------------------------------------------
module tb_page_mapping_table;

  import pmt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned RANDOM_OPS  = 1100;
  localparam int unsigned STALL_PCT   = 28;
  localparam int unsigned HANG_LIMIT  = 4000;
  localparam int unsigned KEY_COUNT   = 24;
  // cycle window in which the result side never stalls
  localparam int unsigned CALM_FROM   = 10000;
  localparam int unsigned CALM_TO     = 16000;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [PPAGE_W-1:0]  ppage;
    logic                writable;
  } reply_t;

  // --------------------------------------------------------------------------
  // Tracker: private copy of the mapping table plus the replies still owed
  // --------------------------------------------------------------------------
  class translation_tracker;
    logic [VPAGE_W-1:0] vpage_at[TABLE_DEPTH];
    logic [PPAGE_W-1:0] ppage_at[TABLE_DEPTH];
    logic               wr_at[TABLE_DEPTH];
    int unsigned        fill;
    reply_t             owed[$];
    int                 faults;

    function new();
      fill   = 0;
      faults = 0;
    endfunction

    // work out the reply for an accepted request and update the table
    function void note_request(logic cmd, logic [VPAGE_W-1:0] vpage,
                               logic [PPAGE_W-1:0] ppage, logic wr);
      reply_t r;
      int     slot;
      slot       = -1;
      r.status   = ST_OK;
      r.ppage    = '0;
      r.writable = 1'b0;
      for (int i = 0; i < int'(fill); i++) begin
        if (slot < 0 && vpage_at[i] == vpage) slot = i;
      end
      if (cmd == CMD_MAP) begin
        if (slot >= 0) begin
          ppage_at[slot] = ppage;
          wr_at[slot]    = wr;
        end else if (fill >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          vpage_at[fill] = vpage;
          ppage_at[fill] = ppage;
          wr_at[fill]    = wr;
          fill++;
        end
      end else begin
        if (slot >= 0) begin
          r.ppage    = ppage_at[slot];
          r.writable = wr_at[slot];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      owed.push_back(r);
    endfunction

    // compare a returned transfer with the oldest owed reply
    function void check_reply(logic [STATUS_W-1:0] status,
                              logic [PPAGE_W-1:0] ppage, logic wr);
      reply_t r;
      if (owed.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("[%0t] unexpected result: status=%0d ppage=%h wr=%b",
                   $realtime, status, ppage, wr);
      end else begin
        r = owed.pop_front();
        if (status !== r.status || ppage !== r.ppage || wr !== r.writable) begin
          faults++;
          if (faults <= 10)
            $display("[%0t] mismatch: exp status=%0d ppage=%h wr=%b, got status=%0d ppage=%h wr=%b",
                     $realtime, r.status, r.ppage, r.writable, status, ppage, wr);
        end
      end
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block signals
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_command = CMD_MAP;
  logic [VPAGE_W-1:0]  in_virtual_page = '0;
  logic [PPAGE_W-1:0]  in_new_physical_page = '0;
  logic                in_new_writable = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [PPAGE_W-1:0]  out_found_physical_page;
  logic                out_found_writable;

  translation_tracker  tracker = new();
  logic [VPAGE_W-1:0]  key_pool[KEY_COUNT];
  bit                  steady_send = 1'b0;
  int unsigned         cyc = 0;
  int unsigned         hang_count = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  page_mapping_table #(
    .MAX_ENTRIES (TABLE_DEPTH)
  ) dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_command              (in_command),
    .in_virtual_page         (in_virtual_page),
    .in_new_physical_page    (in_new_physical_page),
    .in_new_writable         (in_new_writable),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_status              (out_status),
    .out_found_physical_page (out_found_physical_page),
    .out_found_writable      (out_found_writable)
  );

  // Result side: random stalls, none inside the calm window
  always @(posedge clk) begin
    if (cyc >= CALM_FROM && cyc < CALM_TO) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < STALL_PCT);
    end
  end

  // Result checking on every accepted transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_reply(out_status, out_found_physical_page, out_found_writable);
  end

  // Watchdog: cycles without any transfer on either channel
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver: optional idle cycles, then hold until the transfer
  // --------------------------------------------------------------------------
  task automatic issue_request(logic cmd, logic [VPAGE_W-1:0] vpage,
                               logic [PPAGE_W-1:0] ppage, logic wr);
    while (!steady_send && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_command           <= cmd;
    in_virtual_page      <= vpage;
    in_new_physical_page <= ppage;
    in_new_writable      <= wr;
    do @(posedge clk); while (in_stall);
    tracker.note_request(cmd, vpage, ppage, wr);
  endtask

  function automatic logic [VPAGE_W-1:0] any_vpage();
    logic [VPAGE_W-1:0] v;
    v[31:0]         = $urandom();
    v[VPAGE_W-1:32] = $urandom();
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [VPAGE_W-1:0] vp;
    int                 pick;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < int'(KEY_COUNT); i++) key_pool[i] = any_vpage();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-table miss, extremes, update in place, plain miss
    issue_request(CMD_TRANSLATE, key_pool[0], '0, 1'b0);
    issue_request(CMD_MAP, key_pool[0], '1, 1'b1);
    issue_request(CMD_MAP, key_pool[1], '0, 1'b0);
    issue_request(CMD_TRANSLATE, key_pool[0], '1, 1'b1);
    issue_request(CMD_TRANSLATE, key_pool[1], '0, 1'b0);
    issue_request(CMD_MAP, key_pool[0], 20'h5A5A5, 1'b0);
    issue_request(CMD_TRANSLATE, key_pool[0], '0, 1'b1);
    issue_request(CMD_TRANSLATE, key_pool[16], '0, 1'b0);
    // fill the table, then hit it when full
    for (int i = 2; i < int'(TABLE_DEPTH); i++)
      issue_request(CMD_MAP, key_pool[i], PPAGE_W'($urandom()), 1'($urandom()));
    issue_request(CMD_MAP, key_pool[16], '1, 1'b1);
    issue_request(CMD_MAP, key_pool[1], 20'hA5A5A, 1'b1);
    issue_request(CMD_TRANSLATE, key_pool[1], '0, 1'b0);
    issue_request(CMD_TRANSLATE, key_pool[17], '0, 1'b0);

    // random: mostly pages held in the table, some absent, some arbitrary
    for (int n = 0; n < int'(RANDOM_OPS); n++) begin
      steady_send = (n >= 500 && n < 700);
      pick = $urandom_range(0, 99);
      if (pick < 70)      vp = key_pool[$urandom_range(0, TABLE_DEPTH - 1)];
      else if (pick < 90) vp = key_pool[$urandom_range(TABLE_DEPTH, KEY_COUNT - 1)];
      else                vp = any_vpage();
      issue_request(1'($urandom()), vp, PPAGE_W'($urandom()), 1'($urandom()));
    end
    in_valid <= 1'b0;

    // drain, then allow for any stray result
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    if (tracker.faults == 0 && tracker.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
